// ----- sv/dvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dvc_pkg;

    // store capacity and derived widths
    localparam int MAX_ITEMS = 1024;
    localparam int VALUE_W   = 30;
    localparam int COUNT_W   = 11;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic insert;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic hit;
        logic miss;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/distinct_value_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Counts the distinct values of a set that arrives one value per item, with
// i_last on the set's final value. Each value is searched in an on-chip store
// of the set's distinct values, read one entry per cycle through the store's
// registered read port; an absent value is appended. A new item is taken only
// once the search of the previous one has ended, and the last item of a set
// also loads the result register. After the last item one result gives the
// distinct count, saturated at MAX_ITEMS, and o_overflow set if the set held
// more distinct values than the store holds; the count then clears for the
// next set. Intake goes on while a result waits on i_stall, until the next
// set's last item needs the result register.

module distinct_value_counter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [dvc_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [dvc_pkg::COUNT_W-1:0]      o_distinct_count,
    output logic                             o_overflow
);

    dvc_pkg::t_dp_cmd    cmd;
    dvc_pkg::t_dp_status status;

    // sequencer
    dvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // store, search and result datapath
    dvc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_value          (i_value),
        .i_last           (i_last),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_distinct_count (o_distinct_count),
        .o_overflow       (o_overflow)
    );

endmodule

`default_nettype wire

// ----- sv/dvc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvc_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [dvc_pkg::VALUE_W-1:0] i_value,
    input  wire logic                      i_last,
    input  wire logic                      i_stall,
    input  wire dvc_pkg::t_dp_cmd          i_cmd,
    output dvc_pkg::t_dp_status            o_status,
    output logic                           o_valid,
    output logic [dvc_pkg::COUNT_W-1:0]    o_distinct_count,
    output logic                           o_overflow
);

    localparam logic [dvc_pkg::CNT_W-1:0] CAP = dvc_pkg::CNT_W'(dvc_pkg::MAX_ITEMS);

    logic [dvc_pkg::VALUE_W-1:0] r_mem [dvc_pkg::MAX_ITEMS];
    logic [dvc_pkg::VALUE_W-1:0] r_value;
    logic                        r_last;
    logic [dvc_pkg::CNT_W-1:0]   r_count;
    logic                        r_ovf;
    logic [dvc_pkg::CNT_W-1:0]   r_idx;
    logic                        r_rd_vld;
    logic [dvc_pkg::VALUE_W-1:0] r_rdata;
    logic                        r_out_vld;
    logic [dvc_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_ovf;
    logic                        rd_en;
    logic                        wr_en;
    logic                        full;
    logic                        out_free;

    assign full     = (r_count == CAP);
    assign rd_en    = i_cmd.scan && (r_idx != r_count);
    assign wr_en    = i_cmd.insert && !full;
    assign out_free = !r_out_vld || !i_stall;

    // status back to the controller
    always_comb begin
        o_status.hit      = r_rd_vld && (r_rdata == r_value);
        o_status.miss     = !r_rd_vld && (r_idx == r_count);
        o_status.last     = r_last;
        o_status.out_free = out_free;
    end

    // store of distinct values, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[dvc_pkg::ADDR_W-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[dvc_pkg::ADDR_W-1:0]];
        end
    end

    // latch the incoming item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
    end

    // scan pointer and read pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // distinct count and overflow flag of the current set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.insert) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_count <= dvc_pkg::COUNT_W'(r_count);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_distinct_count = r_out_count;
    assign o_overflow       = r_out_ovf;

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("distinct count above capacity");

    // overflow only once the store is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flag with free store entries");

    // a result is never written over one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- sv/dvc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire dvc_pkg::t_dp_status i_status,
    output logic                    o_stall,
    output dvc_pkg::t_dp_cmd        o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.miss) begin
                    o_cmd.insert = !i_status.hit;
                    n_state      = i_status.last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    // an item is taken only when idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_stall)
        else $error("item taken while busy");

    // the store grows only at the end of a search
    a_insert_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> (r_state == ST_SCAN))
        else $error("insert outside a search");

    // a result is loaded only into a free result register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded while register busy");

endmodule

`default_nettype wire

// ----- tb/tb_distinct_value_counter.sv -----
`timescale 1ns / 1ps

module tb_distinct_value_counter;

    localparam int RANDOM_ITEMS = 555;
    // one item can scan the whole store; allow for sender gaps and receiver stalls too
    localparam int IDLE_LIMIT   = 4 * (dvc_pkg::MAX_ITEMS + 4 + 64);
    localparam int DRAIN_CYCLES = 2 * (dvc_pkg::MAX_ITEMS + 4);

    typedef struct packed {
        logic [dvc_pkg::VALUE_W-1:0] value;
        logic                        last;
    } t_set_item;

    typedef struct packed {
        logic [dvc_pkg::COUNT_W-1:0] count;
        logic                        overflow;
    } t_set_result;

    typedef enum int {
        STALL_NONE,
        STALL_HEAVY,
        STALL_TOGGLE,
        STALL_RANDOM
    } t_stall_mode;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic [dvc_pkg::VALUE_W-1:0] i_value = '0;
    logic                        i_last  = 1'b0;
    logic                        i_stall = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [dvc_pkg::COUNT_W-1:0] o_distinct_count;
    logic                        o_overflow;

    t_set_item   pending_items[$];
    t_set_result expected_counts[$];

    // predicted contents of the current set
    bit          member_seen[bit [dvc_pkg::VALUE_W-1:0]];
    int          member_count = 0;
    bit          set_overflow = 1'b0;

    int          errors       = 0;
    int          items_in     = 0;
    int          results_out  = 0;
    int          max_distinct = 0;
    int          burst_left   = 1;
    int          gap_left     = 0;
    int          stall_span   = 0;
    t_stall_mode stall_mode   = STALL_NONE;
    int          idle_cycles  = 0;

    distinct_value_counter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_distinct_count (o_distinct_count),
        .o_overflow       (o_overflow)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // membership update for one accepted item, result queued on the set's last item
    function automatic void count_distinct_step(input logic [dvc_pkg::VALUE_W-1:0] value,
                                                input logic last);
        t_set_result res;
        if (!member_seen.exists(value)) begin
            if (member_count < dvc_pkg::MAX_ITEMS) begin
                member_seen[value] = 1'b1;
                member_count++;
            end else begin
                set_overflow = 1'b1;
            end
        end
        if (last) begin
            res.count    = dvc_pkg::COUNT_W'(member_count);
            res.overflow = set_overflow;
            expected_counts = {expected_counts, res};
            member_seen.delete();
            member_count = 0;
            set_overflow = 1'b0;
        end
    endfunction

    function automatic logic [dvc_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return dvc_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic [dvc_pkg::VALUE_W-1:0] value, input logic last);
        t_set_item it;
        it.value = value;
        it.last  = last;
        pending_items = {pending_items, it};
    endtask

    // random sets, mostly short, drawn from a small pool so values repeat
    task automatic add_random_sets(input int n_items);
        logic [dvc_pkg::VALUE_W-1:0] pool[8];
        logic [dvc_pkg::VALUE_W-1:0] v;
        int                          set_len;
        int                          pool_n;
        int                          left;
        left = n_items;
        while (left > 0) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            pool_n  = $urandom_range(1, 8);
            for (int k = 0; k < pool_n; k++)
                pool[k] = random_value();
            for (int j = 0; j < set_len; j++) begin
                v = ($urandom_range(0, 3) == 0) ? random_value()
                                                : pool[$urandom_range(0, pool_n - 1)];
                add_item(v, j == set_len - 1);
            end
            left -= set_len;
        end
    endtask

    // item driver: bursts with random gaps
    always @(posedge i_clk) begin : drv
        t_set_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                count_distinct_step(i_value, i_last);
                items_in++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_value <= nxt.value;
                    i_last  <= nxt.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, switching mode every so often
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_span = $urandom_range(16, 200);
            end else begin
                stall_span--;
            end
            case (stall_mode)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: i_stall <= ~i_stall;
                default:      i_stall <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_set_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            results_out++;
            if (expected_counts.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got count=%0d overflow=%0b",
                         $time, o_distinct_count, o_overflow);
            end else begin
                exp_res = expected_counts.pop_front();
                if (o_distinct_count !== exp_res.count) begin
                    errors++;
                    $display("%0t: distinct_count expected %0d got %0d",
                             $time, exp_res.count, o_distinct_count);
                end
                if (o_overflow !== exp_res.overflow) begin
                    errors++;
                    $display("%0t: overflow expected %0b got %0b",
                             $time, exp_res.overflow, o_overflow);
                end
                if (int'(exp_res.count) > max_distinct)
                    max_distinct = int'(exp_res.count);
            end
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[distinct_value_counter] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        // single-value sets at both ends of the range
        add_item('0, 1'b1);
        add_item('1, 1'b1);
        // repeats only
        add_item(30'd5, 1'b0);
        add_item(30'd5, 1'b0);
        add_item(30'd5, 1'b1);
        // extremes and alternating bits, last value a repeat
        add_item('0, 1'b0);
        add_item('1, 1'b0);
        add_item(30'h2AAAAAAA, 1'b0);
        add_item(30'h15555555, 1'b0);
        add_item('0, 1'b0);
        add_item('1, 1'b1);
        // last value absent from the store
        add_item(30'd7, 1'b0);
        add_item(30'd8, 1'b0);
        add_item(30'd7, 1'b0);
        add_item(30'd9, 1'b1);
        add_item(30'd1, 1'b0);
        add_item(30'd2, 1'b1);
        add_random_sets(RANDOM_ITEMS);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d items in %0d checked sets, largest distinct count %0d",
                 items_in, results_out, max_distinct);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("[distinct_value_counter] OK");
        else
            $display("[distinct_value_counter] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dvc_pkg.sv
sv/dvc_datapath.sv
sv/dvc_ctrl.sv
sv/distinct_value_counter.sv
tb/tb_distinct_value_counter.sv
